/* sv/assert_macros.svh */
// Assertion macros used by the RTL of the timer table scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: %m");
// Same-cycle implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* sv/tts_pkg.sv */
// Types, codes and constants of the timer table scheduler.
package tts_pkg;

    localparam int SLOTS   = 16;
    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TIME_W  = 48;
    localparam int DELAY_W = 32;
    localparam int ID_W    = 31;

    localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);
    localparam logic [ID_W-1:0] ID_MAX   = {ID_W{1'b1}};

    // Request codes
    typedef enum logic [1:0] {
        REQ_SCHED  = 2'd0,
        REQ_CANCEL = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_SCHED = 2'd0,
        KIND_FIRED = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_REPLY = 2'd3
    } t_kind;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2
    } t_status;

    // Sequencer states
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_FREE   = 7'b0000010,
        S_WRITE  = 7'b0000100,
        S_CANCEL = 7'b0001000,
        S_PEND   = 7'b0010000,
        S_MIN    = 7'b0100000,
        S_UPD    = 7'b1000000
    } t_state;

    // Operands of the shared time/id unit
    typedef struct packed {
        logic [TIME_W-1:0]  now;
        logic [DELAY_W-1:0] addend;
        logic [TIME_W-1:0]  due;
        logic [ID_W-1:0]    id_a;
        logic [ID_W-1:0]    id_b;
    } t_alu_in;

    // Results of the shared time/id unit
    typedef struct packed {
        logic [TIME_W-1:0] due_next;
        logic              due_le;
        logic              id_lt;
    } t_alu_out;

endpackage

/* sv/tts_alu.sv */
// Shared time/id unit: saturating due-time add, due compare, identifier compare.
module tts_alu (
    input  tts_pkg::t_alu_in  i_op,
    output tts_pkg::t_alu_out o_res
);

    logic [tts_pkg::TIME_W:0] w_sum;

    // now + addend, clamped at the largest time value
    assign w_sum = {1'b0, i_op.now} + {{(tts_pkg::TIME_W + 1 - tts_pkg::DELAY_W){1'b0}},
                                       i_op.addend};

    always_comb begin
        o_res.due_next = w_sum[tts_pkg::TIME_W] ? {tts_pkg::TIME_W{1'b1}}
                                                : w_sum[tts_pkg::TIME_W-1:0];
        o_res.due_le   = (i_op.due <= i_op.now);
        o_res.id_lt    = (i_op.id_a < i_op.id_b);
    end

endmodule

/* sv/timer_table_scheduler_core.sv */
// Top level of the timer table scheduler: slot table, sequencer and result register.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+---------------------------------------------
//  request | in        | i_valid / o_stall | i_req_type i_now_ms i_delay_ms i_repeating
//          |           |                   | i_target_id
//  result  | out       | o_valid / i_stall | o_kind o_timer_id o_status o_any_fired o_last
//
// One request at a time; a sequencer walks the slots one per cycle through a shared
// add/compare unit. A schedule scans for the lowest free slot and then writes it; a cancel
// scans for the matching entry. A tick runs a due scan, then one min-id scan per firing timer
// plus a final one, and an update step after each hit; results wait in the output register.
// Reset (synchronous, active low) empties the table and restarts identifiers at 1.
// A stalled result holds the sequencer; o_stall stays high until the last result leaves.
`include "assert_macros.svh"
module timer_table_scheduler_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_req_type,
    input  logic [tts_pkg::TIME_W-1:0]   i_now_ms,
    input  logic [tts_pkg::DELAY_W-1:0]  i_delay_ms,
    input  logic                         i_repeating,
    input  logic [tts_pkg::ID_W-1:0]     i_target_id,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_kind,
    output logic [tts_pkg::ID_W-1:0]     o_timer_id,
    output logic [1:0]                   o_status,
    output logic                         o_any_fired,
    output logic                         o_last
);

    localparam logic [tts_pkg::IDX_W-1:0] LAST_IDX = tts_pkg::IDX_W'(tts_pkg::SLOTS - 1);

    // Slot table
    logic [tts_pkg::SLOTS-1:0]   r_live, n_live;
    logic [tts_pkg::ID_W-1:0]    r_slot_ident    [tts_pkg::SLOTS];
    logic [tts_pkg::TIME_W-1:0]  r_slot_due      [tts_pkg::SLOTS];
    logic [tts_pkg::DELAY_W-1:0] r_slot_interval [tts_pkg::SLOTS];
    logic                        r_slot_periodic [tts_pkg::SLOTS];

    // Sequencer and latched request
    tts_pkg::t_state             r_state, n_state;
    tts_pkg::t_req               r_op, n_op;
    logic [tts_pkg::TIME_W-1:0]  r_now, n_now;
    logic [tts_pkg::DELAY_W-1:0] r_delay, n_delay;
    logic                        r_rep, n_rep;
    logic [tts_pkg::ID_W-1:0]    r_target, n_target;
    logic [tts_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic [tts_pkg::IDX_W-1:0]   r_best, n_best;
    logic [tts_pkg::ID_W-1:0]    r_best_id, n_best_id;
    logic                        r_found, n_found;
    logic [tts_pkg::SLOTS-1:0]   r_pend, n_pend;
    logic                        r_any, n_any;
    logic [tts_pkg::ID_W-1:0]    r_next_id, n_next_id;

    // Result register
    logic                        r_o_valid, n_o_valid;
    tts_pkg::t_kind              r_o_kind, n_o_kind;
    logic [tts_pkg::ID_W-1:0]    r_o_id, n_o_id;
    tts_pkg::t_status            r_o_status, n_o_status;
    logic                        r_o_any, n_o_any;
    logic                        r_o_last, n_o_last;

    // Slot write controls
    logic                        w_wr_new;
    logic                        w_wr_due;
    logic [tts_pkg::IDX_W-1:0]   w_rd_idx;
    tts_pkg::t_alu_in            w_alu_in;
    tts_pkg::t_alu_out           w_alu_out;

    // Result kinds seen by the checks
    logic                        w_out_done;
    logic                        w_out_fired;

    // Single read address into the slot table
    assign w_rd_idx = (r_state == tts_pkg::S_UPD || r_state == tts_pkg::S_WRITE) ? r_best
                                                                                  : r_idx;

    always_comb begin
        w_alu_in.now    = r_now;
        w_alu_in.addend = (r_op == tts_pkg::REQ_SCHED) ? r_delay : r_slot_interval[w_rd_idx];
        w_alu_in.due    = r_slot_due[w_rd_idx];
        w_alu_in.id_a   = r_slot_ident[w_rd_idx];
        w_alu_in.id_b   = r_best_id;
    end

    tts_alu u_alu (
        .i_op  (w_alu_in),
        .o_res (w_alu_out)
    );

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_now      = r_now;
        n_delay    = r_delay;
        n_rep      = r_rep;
        n_target   = r_target;
        n_idx      = r_idx;
        n_best     = r_best;
        n_best_id  = r_best_id;
        n_found    = r_found;
        n_pend     = r_pend;
        n_any      = r_any;
        n_next_id  = r_next_id;
        n_live     = r_live;
        n_o_valid  = r_o_valid;
        n_o_kind   = r_o_kind;
        n_o_id     = r_o_id;
        n_o_status = r_o_status;
        n_o_any    = r_o_any;
        n_o_last   = r_o_last;
        w_wr_new   = 1'b0;
        w_wr_due   = 1'b0;

        case (r_state)
            tts_pkg::S_IDLE: begin
                if (r_o_valid) begin
                    // wait for the result to be taken
                    if (!i_stall) begin
                        n_o_valid = 1'b0;
                        if (!r_o_last) begin
                            n_idx   = '0;
                            n_found = 1'b0;
                            n_state = tts_pkg::S_MIN;
                        end
                    end
                end else if (i_valid) begin
                    n_op       = tts_pkg::t_req'(i_req_type);
                    n_now      = i_now_ms;
                    n_delay    = i_delay_ms;
                    n_rep      = i_repeating;
                    n_target   = i_target_id;
                    n_idx      = '0;
                    n_found    = 1'b0;
                    n_any      = 1'b0;
                    n_o_id     = '0;
                    n_o_status = tts_pkg::ST_OK;
                    n_o_any    = 1'b0;
                    n_o_last   = 1'b1;
                    case (tts_pkg::t_req'(i_req_type))
                        tts_pkg::REQ_SCHED:  n_state = tts_pkg::S_FREE;
                        tts_pkg::REQ_CANCEL: n_state = tts_pkg::S_CANCEL;
                        tts_pkg::REQ_TICK:   n_state = tts_pkg::S_PEND;
                        default: begin
                            // clear all
                            n_live    = '0;
                            n_next_id = tts_pkg::ID_FIRST;
                            n_o_kind  = tts_pkg::KIND_REPLY;
                            n_o_valid = 1'b1;
                        end
                    endcase
                end
            end

            // lowest free slot
            tts_pkg::S_FREE: begin
                if (!r_live[r_idx]) begin
                    n_best  = r_idx;
                    n_state = tts_pkg::S_WRITE;
                end else if (r_idx == LAST_IDX) begin
                    n_o_kind   = tts_pkg::KIND_SCHED;
                    n_o_status = tts_pkg::ST_FULL;
                    n_o_valid  = 1'b1;
                    n_state    = tts_pkg::S_IDLE;
                end else begin
                    n_idx = r_idx + tts_pkg::IDX_W'(1);
                end
            end

            // store the new entry and hand out its identifier
            tts_pkg::S_WRITE: begin
                w_wr_new       = 1'b1;
                n_live[r_best] = 1'b1;
                n_o_kind       = tts_pkg::KIND_SCHED;
                n_o_id         = r_next_id;
                n_o_valid      = 1'b1;
                n_next_id      = (r_next_id == tts_pkg::ID_MAX) ? tts_pkg::ID_FIRST
                                                                : r_next_id + tts_pkg::ID_W'(1);
                n_state        = tts_pkg::S_IDLE;
            end

            // lowest live slot with a matching identifier
            tts_pkg::S_CANCEL: begin
                n_o_kind = tts_pkg::KIND_REPLY;
                if (r_live[r_idx] && r_slot_ident[r_idx] == r_target) begin
                    n_live[r_idx] = 1'b0;
                    n_o_valid     = 1'b1;
                    n_state       = tts_pkg::S_IDLE;
                end else if (r_idx == LAST_IDX) begin
                    n_o_status = tts_pkg::ST_NOTFOUND;
                    n_o_valid  = 1'b1;
                    n_state    = tts_pkg::S_IDLE;
                end else begin
                    n_idx = r_idx + tts_pkg::IDX_W'(1);
                end
            end

            // snapshot of entries due at this tick
            tts_pkg::S_PEND: begin
                n_pend[r_idx] = r_live[r_idx] && w_alu_out.due_le;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_state = tts_pkg::S_MIN;
                end else begin
                    n_idx = r_idx + tts_pkg::IDX_W'(1);
                end
            end

            // pending entry with the smallest identifier, lowest slot on ties
            tts_pkg::S_MIN: begin
                if (r_pend[r_idx] && (!r_found || w_alu_out.id_lt)) begin
                    n_found   = 1'b1;
                    n_best    = r_idx;
                    n_best_id = r_slot_ident[r_idx];
                end
                if (r_idx == LAST_IDX) begin
                    if (n_found) begin
                        n_state = tts_pkg::S_UPD;
                    end else begin
                        n_o_kind   = tts_pkg::KIND_DONE;
                        n_o_id     = '0;
                        n_o_status = tts_pkg::ST_OK;
                        n_o_any    = r_any;
                        n_o_last   = 1'b1;
                        n_o_valid  = 1'b1;
                        n_state    = tts_pkg::S_IDLE;
                    end
                end else begin
                    n_idx = r_idx + tts_pkg::IDX_W'(1);
                end
            end

            // fire: re-arm a periodic entry, free a one-shot entry
            tts_pkg::S_UPD: begin
                n_pend[r_best] = 1'b0;
                if (r_slot_periodic[r_best]) begin
                    w_wr_due = 1'b1;
                end else begin
                    n_live[r_best] = 1'b0;
                end
                n_any      = 1'b1;
                n_o_kind   = tts_pkg::KIND_FIRED;
                n_o_id     = r_best_id;
                n_o_status = tts_pkg::ST_OK;
                n_o_any    = 1'b0;
                n_o_last   = 1'b0;
                n_o_valid  = 1'b1;
                n_state    = tts_pkg::S_IDLE;
            end

            default: begin
                n_state = tts_pkg::S_IDLE;
            end
        endcase
    end

    // Control and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tts_pkg::S_IDLE;
            r_live    <= '0;
            r_pend    <= '0;
            r_next_id <= tts_pkg::ID_FIRST;
            r_o_valid <= 1'b0;
            r_found   <= 1'b0;
            r_any     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_live    <= n_live;
            r_pend    <= n_pend;
            r_next_id <= n_next_id;
            r_o_valid <= n_o_valid;
            r_found   <= n_found;
            r_any     <= n_any;
        end
        r_op       <= n_op;
        r_now      <= n_now;
        r_delay    <= n_delay;
        r_rep      <= n_rep;
        r_target   <= n_target;
        r_idx      <= n_idx;
        r_best     <= n_best;
        r_best_id  <= n_best_id;
        r_o_kind   <= n_o_kind;
        r_o_id     <= n_o_id;
        r_o_status <= n_o_status;
        r_o_any    <= n_o_any;
        r_o_last   <= n_o_last;
    end

    // Slot table writes
    always_ff @(posedge i_clk) begin
        if (w_wr_new) begin
            r_slot_ident[r_best]    <= r_next_id;
            r_slot_due[r_best]      <= w_alu_out.due_next;
            r_slot_interval[r_best] <= r_delay;
            r_slot_periodic[r_best] <= r_rep;
        end else if (w_wr_due) begin
            r_slot_due[r_best]      <= w_alu_out.due_next;
        end
    end

    // Ports
    assign o_stall     = (r_state != tts_pkg::S_IDLE) || r_o_valid;
    assign o_valid     = r_o_valid;
    assign o_kind      = r_o_kind;
    assign o_timer_id  = r_o_id;
    assign o_status    = r_o_status;
    assign o_any_fired = r_o_any;
    assign o_last      = r_o_last;

    assign w_out_done  = r_o_valid && (r_o_kind == tts_pkg::KIND_DONE);
    assign w_out_fired = r_o_valid && (r_o_kind == tts_pkg::KIND_FIRED);

    // Checks
    `ASSERT_ALWAYS(a_pend_live, i_clk, i_rst_n, (r_pend & ~r_live) == '0)
    `ASSERT_ALWAYS(a_next_id_nz, i_clk, i_rst_n, r_next_id != '0)
    `ASSERT_IMPLY(a_out_in_idle, i_clk, i_rst_n, r_o_valid, r_state == tts_pkg::S_IDLE)
    `ASSERT_IMPLY(a_done_last, i_clk, i_rst_n, w_out_done, r_o_last)
    `ASSERT_IMPLY(a_fired_tick, i_clk, i_rst_n, w_out_fired, !r_o_last && r_op == tts_pkg::REQ_TICK)

endmodule
